>>> src/assert_macros.svh
// Assertion macros used by the controller module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define PMB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge.
`define PMB_NEVER(lbl, clk, rst_n, cond, msg) \
    `PMB_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> src/pmb_pkg.sv
`timescale 1ns / 1ps

package pmb_pkg;

    // Widths of the stream item fields, the configuration fields and the weight.
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;
    localparam int MASK_W    = 17;
    localparam int CHAN_W    = 16;
    localparam int LVC_W     = 5;
    localparam int GAMMA_W   = 16;
    localparam int W_W       = 24;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA_FACTOR = 1'd1;

    // Reset value of the gamma factor register.
    localparam logic [GAMMA_W-1:0] GAMMA_ONE = 16'd256;

    // Divider widths: largest dividend is a 32-bit magnitude shifted by 16.
    localparam int DIV_DW = 48;
    localparam int DIV_VW = 31;

    // Fixed-point widths of the power unit.
    localparam int X_W    = 31;
    localparam int Q_W    = 37;
    localparam int MAG_W  = 29;
    localparam int STEPS  = 24;

    // Datapath operation codes issued by the controller.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
    localparam logic [OP_W-1:0] OP_PSTART = 5'd1;
    localparam logic [OP_W-1:0] OP_NORM   = 5'd2;
    localparam logic [OP_W-1:0] OP_LOG    = 5'd3;
    localparam logic [OP_W-1:0] OP_MAG    = 5'd4;
    localparam logic [OP_W-1:0] OP_QWAIT  = 5'd5;
    localparam logic [OP_W-1:0] OP_EXPI   = 5'd6;
    localparam logic [OP_W-1:0] OP_EXP    = 5'd7;
    localparam logic [OP_W-1:0] OP_PFIN   = 5'd8;
    localparam logic [OP_W-1:0] OP_SEG    = 5'd9;
    localparam logic [OP_W-1:0] OP_DLO    = 5'd10;
    localparam logic [OP_W-1:0] OP_XWAIT  = 5'd11;
    localparam logic [OP_W-1:0] OP_STLO   = 5'd12;
    localparam logic [OP_W-1:0] OP_STHI   = 5'd13;
    localparam logic [OP_W-1:0] OP_DW     = 5'd14;
    localparam logic [OP_W-1:0] OP_WWAIT  = 5'd15;
    localparam logic [OP_W-1:0] OP_BLEND  = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            take;
        logic [OP_W-1:0] op;
        logic [4:0]      cnt;
        logic            inverse;
        logic            out_load;
    } pmb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_mask;
        logic trivial;
        logic use_gamma;
        logic emit;
        logic passthrough;
        logic xw_zero;
        logic norm_done;
        logic ip_big;
        logic div_done;
    } pmb_stat_t;

    // Table of successive square roots of one half, Q1.30.
    typedef logic [X_W-1:0] root_tab_t [0:STEPS];

    // Floor square root, one result bit per pass.
    function automatic logic [63:0] isqrt64(input logic [63:0] a);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = a;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic root_tab_t build_roots();
        root_tab_t   t;
        logic [63:0] v;
        t[0] = X_W'(64'd1 << 30);
        v    = isqrt64(64'd1 << 59);
        t[1] = v[X_W-1:0];
        for (int k = 2; k <= STEPS; k++) begin
            v    = isqrt64({33'd0, t[k-1]} << 30);
            t[k] = v[X_W-1:0];
        end
        return t;
    endfunction

endpackage

>>> src/pmb_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module pmb_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pmb_pkg::DIV_DW-1:0]    dividend,
    input  logic [pmb_pkg::DIV_VW-1:0]    divisor,
    output logic                          done,
    output logic [pmb_pkg::DIV_DW-1:0]    quotient
);

    localparam int DW  = pmb_pkg::DIV_DW;
    localparam int VW  = pmb_pkg::DIV_VW;
    localparam int CW  = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          fits;

    // Shift the next dividend bit into the partial remainder.
    always_comb begin
        trial = {rem_reg, quo_reg[DW-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    // Control: busy flag, step count and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/pmb_datapath.sv
`timescale 1ns / 1ps

// Registers, arithmetic and the shared divider of the blend.
module pmb_datapath #(
    parameter int MAX_LEVELS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pmb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pmb_pkg::GAMMA_W-1:0]       cfg_wr_data,
    input  logic [pmb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [0:0]                        s_tuser,
    input  pmb_pkg::pmb_cmd_t                 cmd,
    output pmb_pkg::pmb_stat_t                stat,
    output logic [pmb_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int SEG_W = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W = $clog2(MAX_LEVELS + 1);
    localparam int LVC_W = pmb_pkg::LVC_W;
    localparam int X_W   = pmb_pkg::X_W;
    localparam int Q_W   = pmb_pkg::Q_W;
    localparam int MAG_W = pmb_pkg::MAG_W;
    localparam int W_W   = pmb_pkg::W_W;
    localparam int DW    = pmb_pkg::DIV_DW;
    localparam int VW    = pmb_pkg::DIV_VW;
    localparam pmb_pkg::root_tab_t ROOT_TAB = pmb_pkg::build_roots();

    // Configuration and pixel state.
    logic [LVC_W-1:0]              level_count_reg;
    logic [pmb_pkg::GAMMA_W-1:0]   gamma_reg;
    logic [SEG_W-1:0]              seg_reg;
    logic signed [W_W-1:0]         w_reg;
    logic [63:0]                   lower_reg;
    logic [63:0]                   upper_reg;
    logic [CNT_W-1:0]              seen_reg;

    // Working registers of the mask computation.
    logic signed [pmb_pkg::MASK_W-1:0] mask_reg;
    logic [X_W-1:0]                xw_reg;
    logic [X_W-1:0]                m_reg;
    logic [4:0]                    sh_reg;
    logic [23:0]                   frac_reg;
    logic [Q_W-1:0]                q_reg;
    logic [X_W-1:0]                r_reg;
    logic [X_W-1:0]                lo_reg;
    logic [X_W-1:0]                hi_reg;
    logic [63:0]                   res_reg;
    logic [63:0]                   out_reg;

    // Combinational terms.
    logic [LVC_W-1:0]              lv;
    logic [pmb_pkg::GAMMA_W-1:0]   g_eff;
    logic                          use_gamma;
    logic                          trivial;
    logic signed [pmb_pkg::MASK_W-1:0] in_mask;
    logic [63:0]                   in_item;
    logic [X_W-1:0]                x_clamp;
    logic                          k_in_range;
    logic                          k_last;
    logic [MAG_W-1:0]              mag;
    logic [61:0]                   sq;
    logic [31:0]                   sq_t;
    logic [44:0]                   fwd_p;
    logic [12:0]                   ip;
    logic [4:0]                    k_idx;
    logic [61:0]                   rp;
    logic [35:0]                   sp;
    logic [5:0]                    seg_raw;
    logic [5:0]                    seg_cap;
    logic [SEG_W-1:0]              seg_calc;
    logic signed [33:0]            num;
    logic [31:0]                   num_mag;
    logic signed [31:0]            den_diff;
    logic [VW-1:0]                 den;
    logic [W_W-1:0]                w_calc;
    logic                          div_start;
    logic [DW-1:0]                 div_dvd;
    logic [VW-1:0]                 div_dvs;
    logic                          div_done;
    logic [DW-1:0]                 div_quo;
    logic [5:0]                    ch_idx;
    logic [15:0]                   ch_a;
    logic [15:0]                   ch_b;
    logic signed [16:0]            ch_diff;
    logic signed [40:0]            ch_prod;
    logic signed [41:0]            ch_round;
    logic signed [26:0]            ch_sum;
    logic [15:0]                   ch_sat;

    // Effective level count and gamma.
    always_comb begin
        if (32'(level_count_reg) > MAX_LEVELS) begin
            lv = LVC_W'(MAX_LEVELS);
        end else begin
            lv = level_count_reg;
        end
        g_eff     = (lv > LVC_W'(2)) ? gamma_reg : pmb_pkg::GAMMA_ONE;
        use_gamma = g_eff != pmb_pkg::GAMMA_ONE;
        trivial   = (lv < LVC_W'(2)) || (g_eff == '0);
    end

    // Input fields and the clamped mask in Q1.30.
    always_comb begin
        in_mask = $signed(s_tdata[16:0]);
        in_item = s_tdata[80:17];
        if (in_mask[16]) begin
            x_clamp = '0;
        end else if (in_mask > 17'sd32768) begin
            x_clamp = X_W'(32'd32768 << 15);
        end else begin
            x_clamp = {in_mask[15:0], 15'd0};
        end
        k_in_range = 32'(seen_reg) < 32'(lv);
        k_last     = 32'(seen_reg) == 32'(lv) - 1;
    end

    // Log, power and exponent arithmetic.
    always_comb begin
        mag   = {sh_reg, 24'd0} - {5'd0, frac_reg};
        sq    = m_reg * m_reg;
        sq_t  = sq[61:30];
        fwd_p = mag * g_eff;
        ip    = q_reg[Q_W-1:24];
        k_idx = cmd.cnt + 5'd1;
        rp    = r_reg * ROOT_TAB[k_idx];
    end

    // Segment choice and weight terms.
    always_comb begin
        sp       = xw_reg * (lv - LVC_W'(1));
        seg_raw  = sp[35:30];
        seg_cap  = 6'(lv - LVC_W'(2));
        seg_calc = (seg_raw > seg_cap) ? SEG_W'(seg_cap) : SEG_W'(seg_raw);
        num      = {{2{mask_reg[16]}}, mask_reg, 15'd0} - $signed({3'd0, lo_reg});
        num_mag  = num[33] ? 32'(-num) : 32'(num);
        den_diff = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
        den      = (den_diff < 32'sd1) ? VW'(1) : den_diff[VW-1:0];
        if (num[33]) begin
            w_calc = (div_quo > DW'(24'd8388608)) ? 24'h800000 : 24'(-div_quo);
        end else begin
            w_calc = (div_quo > DW'(24'd8388607)) ? 24'h7FFFFF : div_quo[W_W-1:0];
        end
    end

    // Divider operands per operation.
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = VW'(1);
        unique case (cmd.op)
            pmb_pkg::OP_MAG: begin
                div_start = cmd.inverse;
                div_dvd   = DW'(mag) << 8;
                div_dvs   = VW'(g_eff);
            end
            pmb_pkg::OP_DLO: begin
                div_start = 1'b1;
                div_dvd   = DW'(seg_reg) << 30;
                div_dvs   = VW'(lv - LVC_W'(1));
            end
            pmb_pkg::OP_STLO: begin
                div_start = 1'b1;
                div_dvd   = DW'(32'(seg_reg) + 1) << 30;
                div_dvs   = VW'(lv - LVC_W'(1));
            end
            pmb_pkg::OP_DW: begin
                div_start = 1'b1;
                div_dvd   = {num_mag, 16'd0};
                div_dvs   = den;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pmb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // One colour channel of the linear blend.
    always_comb begin
        ch_idx   = {cmd.cnt[1:0], 4'd0};
        ch_a     = lower_reg[ch_idx +: 16];
        ch_b     = upper_reg[ch_idx +: 16];
        ch_diff  = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
        ch_prod  = ch_diff * w_reg;
        ch_round = 42'(ch_prod) + 42'sd32768;
        ch_sum   = $signed({11'd0, ch_a}) + 27'(ch_round >>> 16);
        if (ch_sum < 27'sd0) begin
            ch_sat = '0;
        end else if (ch_sum > 27'sd65535) begin
            ch_sat = 16'hFFFF;
        end else begin
            ch_sat = ch_sum[15:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg <= '0;
            gamma_reg       <= pmb_pkg::GAMMA_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pmb_pkg::REG_LEVEL_COUNT:  level_count_reg <= cfg_wr_data[LVC_W-1:0];
                pmb_pkg::REG_GAMMA_FACTOR: gamma_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Pixel state: segment, weight, captured levels and level count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg   <= '0;
            w_reg     <= '0;
            lower_reg <= '0;
            upper_reg <= '0;
            seen_reg  <= '0;
        end else begin
            if (cmd.take && !s_tuser[0]) begin
                seen_reg <= '0;
                if (trivial) begin
                    seg_reg <= '0;
                    w_reg   <= '0;
                end
            end else if (cmd.take && k_in_range) begin
                if (32'(seen_reg) == 32'(seg_reg)) begin
                    lower_reg <= in_item;
                end
                if (32'(seen_reg) == 32'(seg_reg) + 1) begin
                    upper_reg <= in_item;
                end
                seen_reg <= seen_reg + 1'b1;
            end
            if (cmd.op == pmb_pkg::OP_SEG) begin
                seg_reg <= seg_calc;
            end
            if (cmd.op == pmb_pkg::OP_WWAIT && div_done) begin
                w_reg <= $signed(w_calc);
            end
        end
    end

    // Working registers of the power, division and blend sequences.
    always_ff @(posedge aclk) begin
        if (cmd.take && !s_tuser[0]) begin
            mask_reg <= in_mask;
            xw_reg   <= x_clamp;
        end
        if (cmd.take && s_tuser[0]) begin
            res_reg <= in_item;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
        unique case (cmd.op)
            pmb_pkg::OP_PSTART: begin
                m_reg    <= xw_reg;
                sh_reg   <= '0;
                frac_reg <= '0;
            end
            pmb_pkg::OP_NORM: begin
                if (!m_reg[X_W-1]) begin
                    m_reg  <= m_reg << 1;
                    sh_reg <= sh_reg + 1'b1;
                end
            end
            pmb_pkg::OP_LOG: begin
                m_reg    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                frac_reg <= {frac_reg[22:0], sq_t[31]};
            end
            pmb_pkg::OP_MAG: begin
                q_reg <= fwd_p[44:8];
            end
            pmb_pkg::OP_QWAIT: begin
                if (div_done) begin
                    q_reg <= div_quo[Q_W-1:0];
                end
            end
            pmb_pkg::OP_EXPI: begin
                r_reg <= X_W'(32'd1 << 30);
            end
            pmb_pkg::OP_EXP: begin
                if (q_reg[5'd23 - cmd.cnt]) begin
                    r_reg <= rp[60:30];
                end
            end
            pmb_pkg::OP_PFIN: begin
                xw_reg <= stat.ip_big ? '0 : (r_reg >> ip[4:0]);
            end
            pmb_pkg::OP_XWAIT: begin
                if (div_done) begin
                    xw_reg <= div_quo[X_W-1:0];
                end
            end
            pmb_pkg::OP_STLO: begin
                lo_reg <= xw_reg;
            end
            pmb_pkg::OP_STHI: begin
                hi_reg <= xw_reg;
            end
            pmb_pkg::OP_BLEND: begin
                res_reg[ch_idx +: 16] <= ch_sat;
            end
            default: begin
            end
        endcase
    end

    // Status towards the controller.
    always_comb begin
        stat.item_mask   = !s_tuser[0];
        stat.trivial     = trivial;
        stat.use_gamma   = use_gamma;
        stat.emit        = s_tuser[0] && k_in_range && k_last;
        stat.passthrough = (lv == LVC_W'(1)) || (g_eff == '0);
        stat.xw_zero     = xw_reg == '0;
        stat.norm_done   = m_reg[X_W-1];
        stat.ip_big      = ip > 13'd30;
        stat.div_done    = div_done;
    end

    assign m_tdata = out_reg;

endmodule

>>> src/pmb_ctrl.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Sequencer of the mask computation, the blend and the output register.
module pmb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  pmb_pkg::pmb_stat_t  stat,
    output pmb_pkg::pmb_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PSTART = 5'd1;
    localparam logic [4:0] S_NORM   = 5'd2;
    localparam logic [4:0] S_LOG    = 5'd3;
    localparam logic [4:0] S_MAG    = 5'd4;
    localparam logic [4:0] S_QDIV   = 5'd5;
    localparam logic [4:0] S_EXPI   = 5'd6;
    localparam logic [4:0] S_EXP    = 5'd7;
    localparam logic [4:0] S_PFIN   = 5'd8;
    localparam logic [4:0] S_SEG    = 5'd9;
    localparam logic [4:0] S_DLO    = 5'd10;
    localparam logic [4:0] S_LOWAIT = 5'd11;
    localparam logic [4:0] S_STLO   = 5'd12;
    localparam logic [4:0] S_HIWAIT = 5'd13;
    localparam logic [4:0] S_STHI   = 5'd14;
    localparam logic [4:0] S_DW     = 5'd15;
    localparam logic [4:0] S_WWAIT  = 5'd16;
    localparam logic [4:0] S_BLEND  = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    // Which value the power unit is working on.
    localparam logic [1:0] PH_MASK = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;

    localparam logic [4:0] LAST_STEP = 5'(pmb_pkg::STEPS - 1);
    localparam logic [4:0] LAST_CHAN = 5'd3;

    logic [4:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;
    logic [4:0] post_state;
    logic       out_free;
    logic       div_wait;
    logic       blend_last;

    // Where to continue once the power unit has finished.
    always_comb begin
        unique case (phase_reg)
            PH_MASK: post_state = S_SEG;
            PH_LO:   post_state = S_STLO;
            default: post_state = S_STHI;
        endcase
        out_free   = !m_valid_reg || m_tready;
        div_wait   = (state_reg == S_QDIV) || (state_reg == S_LOWAIT) ||
                     (state_reg == S_HIWAIT) || (state_reg == S_WWAIT);
        blend_last = (state_reg == S_BLEND) && (cnt_reg == LAST_CHAN);
    end

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        cmd.take     = 1'b0;
        cmd.op       = pmb_pkg::OP_NONE;
        cmd.cnt      = cnt_reg;
        cmd.inverse  = phase_reg == PH_MASK;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.take = s_tvalid;
                if (s_tvalid) begin
                    if (stat.item_mask) begin
                        if (!stat.trivial) begin
                            if (stat.use_gamma) begin
                                phase_next = PH_MASK;
                                state_next = S_PSTART;
                            end else begin
                                state_next = S_SEG;
                            end
                        end
                    end else if (stat.emit) begin
                        cnt_next   = '0;
                        state_next = stat.passthrough ? S_OUT : S_BLEND;
                    end
                end
            end
            S_PSTART: begin
                cmd.op     = pmb_pkg::OP_PSTART;
                state_next = stat.xw_zero ? post_state : S_NORM;
            end
            S_NORM: begin
                cmd.op = pmb_pkg::OP_NORM;
                if (stat.norm_done) begin
                    cnt_next   = '0;
                    state_next = S_LOG;
                end
            end
            S_LOG: begin
                cmd.op   = pmb_pkg::OP_LOG;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = S_MAG;
                end
            end
            S_MAG: begin
                cmd.op     = pmb_pkg::OP_MAG;
                state_next = (phase_reg == PH_MASK) ? S_QDIV : S_EXPI;
            end
            S_QDIV: begin
                cmd.op = pmb_pkg::OP_QWAIT;
                if (stat.div_done) begin
                    state_next = S_EXPI;
                end
            end
            S_EXPI: begin
                cmd.op     = pmb_pkg::OP_EXPI;
                cnt_next   = '0;
                state_next = stat.ip_big ? S_PFIN : S_EXP;
            end
            S_EXP: begin
                cmd.op   = pmb_pkg::OP_EXP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = S_PFIN;
                end
            end
            S_PFIN: begin
                cmd.op     = pmb_pkg::OP_PFIN;
                state_next = post_state;
            end
            S_SEG: begin
                cmd.op     = pmb_pkg::OP_SEG;
                state_next = S_DLO;
            end
            S_DLO: begin
                cmd.op     = pmb_pkg::OP_DLO;
                state_next = S_LOWAIT;
            end
            S_LOWAIT: begin
                cmd.op = pmb_pkg::OP_XWAIT;
                if (stat.div_done) begin
                    phase_next = PH_LO;
                    state_next = stat.use_gamma ? S_PSTART : S_STLO;
                end
            end
            S_STLO: begin
                cmd.op     = pmb_pkg::OP_STLO;
                state_next = S_HIWAIT;
            end
            S_HIWAIT: begin
                cmd.op = pmb_pkg::OP_XWAIT;
                if (stat.div_done) begin
                    phase_next = PH_HI;
                    state_next = stat.use_gamma ? S_PSTART : S_STHI;
                end
            end
            S_STHI: begin
                cmd.op     = pmb_pkg::OP_STHI;
                state_next = S_DW;
            end
            S_DW: begin
                cmd.op     = pmb_pkg::OP_DW;
                state_next = S_WWAIT;
            end
            S_WWAIT: begin
                cmd.op = pmb_pkg::OP_WWAIT;
                if (stat.div_done) begin
                    state_next = S_IDLE;
                end
            end
            S_BLEND: begin
                cmd.op   = pmb_pkg::OP_BLEND;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CHAN) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register holds a result until the sink takes it.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            phase_reg   <= PH_MASK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;

    `PMB_NEVER(a_div_done_waited, aclk, aresetn, stat.div_done && !div_wait, "divider done early")
    `PMB_ASSERT(a_load_free, aclk, aresetn, cmd.out_load |-> out_free, "output overwritten")
    `PMB_ASSERT(a_load_shows, aclk, aresetn, cmd.out_load |=> m_valid_reg, "result not presented")
    `PMB_ASSERT(a_blend_ends, aclk, aresetn, blend_last |=> state_reg == S_OUT, "blend did not end")

endmodule

>>> src/piecewise_mask_blend_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Width  Contents
// s_*       in         88+1   tdata: mask_value, level_red, level_green, level_blue,
//                             level_alpha; tuser: command
// m_*       out        64     tdata: out_red, out_green, out_blue, out_alpha
// cfg_*     in         1+16   register index, write data; no read-back
//
// A level item is taken while idle; the last one of a pixel blends four channels,
// unless it passes through, and loads the output register, which waits for the sink.
// A mask item, unless the configuration is trivial, holds the input while the shared
// divider runs, and with gamma also through the 24-step log and exponent loops
// that share one multiplier each.
// Reset is synchronous and active low; it clears control state and pixel state.
// A stalled sink only blocks the input once a further result is ready.
module piecewise_mask_blend_top #(
    parameter int MAX_LEVELS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pmb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pmb_pkg::GAMMA_W-1:0]       cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mask_value[16:0], level_red[32:17], level_green[48:33],
    // level_blue[64:49], level_alpha[80:65], zero pad [87:81]
    input  logic [pmb_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48]
    output logic [pmb_pkg::M_TDATA_W-1:0]     m_tdata
);

    pmb_pkg::pmb_cmd_t  cmd;
    pmb_pkg::pmb_stat_t stat;

    pmb_datapath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tdata     (m_tdata)
    );

    pmb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

endmodule
